>>> src/assert_macros.svh
// Assertion macros for the RTL of the keystream generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARC4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arc4 assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ARC4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arc4 assertion failed");

`endif

>>> src/arc4_pkg.sv
// Package with types, constants and codes of the keystream generator.
package arc4_pkg;

  localparam int PERM_DEPTH        = 256;
  localparam int KEY_STORE_DEPTH   = 128;
  localparam int KEY_BYTES_DEFAULT = 128;
  localparam int KPOS_W            = 9;

  localparam logic [15:0] DISCARD_RESET = 16'd3072;
  localparam logic [30:0] RESEED_RESET  = 31'd400000;

  // Request codes carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_RESET = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_MIX   = 2'd2,
    FUNC_GEN   = 2'd3
  } func_t;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_DISCARD = 1'b0;
  localparam logic [0:0] REG_RESEED  = 1'b1;

  // Operations of the shared byte adder.
  typedef enum logic [1:0] {
    ALU_INC   = 2'd0,
    ALU_JSTEP = 2'd1,
    ALU_TAP   = 2'd2
  } alu_op_t;

  // One access to the permutation store.
  typedef struct packed {
    logic       clear;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage

>>> src/arc4_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module arc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/arc4_perm.sv
// Permutation store: RAM plus per-entry valid bits so that it reads as identity after clear.
module arc4_perm
  import arc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  perm_req_t req,
  output logic [7:0] rdata
);

  logic [PERM_DEPTH-1:0] vld;
  logic                  vld_q;
  logic [7:0]            raddr_q;
  logic [7:0]            ram_rdata;

  arc4_ram #(
    .WIDTH(8),
    .DEPTH(PERM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .raddr(req.raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
    vld_q   <= vld[req.raddr];
    raddr_q <= req.raddr;
  end

  // An entry never written since clear holds its own index.
  assign rdata = vld_q ? ram_rdata : raddr_q;

endmodule

>>> src/arc4_alu.sv
// Shared 8-bit adder that forms every index of the key mix and the keystream.
module arc4_alu
  import arc4_pkg::*;
(
  input  alu_op_t    op,
  input  logic [7:0] index_i,
  input  logic [7:0] index_j,
  input  logic [7:0] lhs,
  input  logic [7:0] rhs,
  input  logic [7:0] key,
  output logic [7:0] sum
);

  logic [7:0] opa;
  logic [7:0] opb;
  logic [7:0] opc;

  always_comb begin
    unique case (op)
      ALU_INC: begin
        opa = index_i;
        opb = 8'd1;
        opc = 8'd0;
      end
      ALU_JSTEP: begin
        opa = index_j;
        opb = lhs;
        opc = key;
      end
      ALU_TAP: begin
        opa = rhs;
        opb = lhs;
        opc = 8'd0;
      end
      default: begin
        opa = 8'd0;
        opb = 8'd0;
        opc = 8'd0;
      end
    endcase
  end

  assign sum = opa + opb + opc;

endmodule

>>> src/arc4_keystream_generator.sv
// Top level of the RC4-style keystream generator: sequencer, registers and ports.
//
// Requests enter on the s_ channel: tuser carries the function code, tdata the
// key index and key byte. Function 0 restores the identity permutation and
// clears the indices and word counter; function 1 stores one key byte.
// Function 2 runs the key mix, 256 swap steps through the states MIX_RD,
// MIX_J, MIX_WI and MIX_WJ, then drops discard_count keystream bytes, each
// through the states GEN_I, GEN_A, GEN_B and GEN_C, and finally loads the
// word counter from reseed_interval. Function 3 produces one 32-bit word on
// the m_ channel: four keystream bytes through the same GEN states, then the
// output state loads the output register. All these steps share the single
// read port and single write port of the permutation RAM, which every byte
// step uses in turn, and one shared adder. s_tready is high only while the
// sequencer is idle. A finished word waits in the output register; if the
// receiver stalls, the next word waits in the output state until the register
// is taken, and no other request is accepted meanwhile. Reset empties the
// output register, reads the permutation as identity at once through per-entry
// valid bits, zeroes the indices and counter and restores the registers to
// their defaults. Key bytes are not cleared and must be loaded before a mix.
`include "assert_macros.svh"

module arc4_keystream_generator
  import arc4_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] key_index, [14:7] key_byte, [15] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] random_word, [32] reseed_due, [39:33] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MIX_RD = 10'b0000000010,
    ST_MIX_J  = 10'b0000000100,
    ST_MIX_WI = 10'b0000001000,
    ST_MIX_WJ = 10'b0000010000,
    ST_GEN_I  = 10'b0000100000,
    ST_GEN_A  = 10'b0001000000,
    ST_GEN_B  = 10'b0010000000,
    ST_GEN_C  = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t      state;
  logic [7:0]  index_i;
  logic [7:0]  index_j;
  logic [7:0]  a_byte;
  logic [7:0]  b_byte;
  logic [7:0]  tap;
  logic        key_ok;
  logic [7:0]  mix_cnt;
  logic [KPOS_W-1:0] kpos;
  logic [15:0] disc_left;
  logic [1:0]  byte_cnt;
  logic        word_mode;
  logic [31:0] word;
  logic [30:0] words_left;
  logic [15:0] discard_count;
  logic [30:0] reseed_interval;

  func_t       func;
  logic        accept;
  logic        cfg_write;
  perm_req_t   perm_req;
  logic [7:0]  perm_rdata;
  logic [7:0]  key_rdata;
  logic [7:0]  key_in;
  alu_op_t     alu_op;
  logic [7:0]  alu_sum;
  logic [7:0]  out_byte;
  logic        kpos_wrap;

  assign func      = func_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_RESEED) ? {1'b0, reseed_interval}
                                              : {16'd0, discard_count};

  // Key store: written by load requests, read in order during the mix.
  arc4_ram #(
    .WIDTH(8),
    .DEPTH(KEY_STORE_DEPTH)
  ) u_key_store (
    .clk  (clk),
    .we   (accept && (func == FUNC_KEY)),
    .waddr(s_tdata[6:0]),
    .wdata(s_tdata[14:7]),
    .raddr(kpos[6:0]),
    .rdata(key_rdata)
  );

  arc4_perm u_perm (
    .clk  (clk),
    .rst  (rst),
    .req  (perm_req),
    .rdata(perm_rdata)
  );

  // Key positions beyond the store read as zero.
  assign key_in = (state == ST_MIX_J && key_ok) ? key_rdata : 8'd0;

  arc4_alu u_alu (
    .op     (alu_op),
    .index_i(index_i),
    .index_j(index_j),
    .lhs    (perm_rdata),
    .rhs    (a_byte),
    .key    (key_in),
    .sum    (alu_sum)
  );

  // The output tap was read before this byte's swap, so a hit on either
  // swapped entry is taken from the values just written.
  assign out_byte = (tap == index_j) ? a_byte :
                    (tap == index_i) ? b_byte : perm_rdata;

  assign kpos_wrap = (kpos == KPOS_W'(KEY_BYTES - 1));

  always_comb begin
    alu_op         = ALU_INC;
    perm_req       = '0;
    perm_req.raddr = index_i;
    unique case (state)
      ST_IDLE: begin
        perm_req.clear = accept && (func == FUNC_RESET);
      end
      ST_MIX_RD: begin
        perm_req.raddr = index_i;
      end
      ST_MIX_J: begin
        alu_op         = ALU_JSTEP;
        perm_req.raddr = alu_sum;
      end
      ST_MIX_WI: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = index_i;
        perm_req.wdata = perm_rdata;
      end
      ST_MIX_WJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = index_j;
        perm_req.wdata = a_byte;
      end
      ST_GEN_I: begin
        perm_req.raddr = alu_sum;
      end
      ST_GEN_A: begin
        alu_op         = ALU_JSTEP;
        perm_req.raddr = alu_sum;
      end
      ST_GEN_B: begin
        alu_op         = ALU_TAP;
        perm_req.raddr = alu_sum;
        perm_req.we    = 1'b1;
        perm_req.waddr = index_i;
        perm_req.wdata = perm_rdata;
      end
      ST_GEN_C: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = index_j;
        perm_req.wdata = a_byte;
      end
      ST_OUT: begin
        perm_req.raddr = index_i;
      end
      default: begin
        perm_req.raddr = index_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      index_i         <= 8'd0;
      index_j         <= 8'd0;
      words_left      <= '0;
      m_tvalid        <= 1'b0;
      discard_count   <= DISCARD_RESET;
      reseed_interval <= RESEED_RESET;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          REG_DISCARD: discard_count   <= pwdata[15:0];
          REG_RESEED:  reseed_interval <= pwdata[30:0];
          default:     discard_count   <= discard_count;
        endcase
      end

      // The output state reloads the register itself when it is taken.
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_RESET: begin
                index_i    <= 8'd0;
                index_j    <= 8'd0;
                words_left <= '0;
              end
              FUNC_KEY: begin
                state <= ST_IDLE;
              end
              FUNC_MIX: begin
                mix_cnt <= 8'd0;
                kpos    <= '0;
                state   <= ST_MIX_RD;
              end
              FUNC_GEN: begin
                if (words_left != '0) begin
                  words_left <= words_left - 31'd1;
                end
                byte_cnt  <= 2'd0;
                word_mode <= 1'b1;
                state     <= ST_GEN_I;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_MIX_RD: begin
          key_ok <= (kpos < KPOS_W'(KEY_STORE_DEPTH));
          state  <= ST_MIX_J;
        end
        ST_MIX_J: begin
          a_byte  <= perm_rdata;
          index_j <= alu_sum;
          state   <= ST_MIX_WI;
        end
        ST_MIX_WI: begin
          state <= ST_MIX_WJ;
        end
        ST_MIX_WJ: begin
          if (mix_cnt == 8'hFF) begin
            // Last step: i stays where it is and j follows it.
            index_j   <= index_i;
            word_mode <= 1'b0;
            disc_left <= discard_count;
            if (discard_count == 16'd0) begin
              words_left <= reseed_interval;
              state      <= ST_IDLE;
            end else begin
              state <= ST_GEN_I;
            end
          end else begin
            index_i <= alu_sum;
            mix_cnt <= mix_cnt + 8'd1;
            kpos    <= kpos_wrap ? '0 : kpos + KPOS_W'(1);
            state   <= ST_MIX_RD;
          end
        end
        ST_GEN_I: begin
          index_i <= alu_sum;
          state   <= ST_GEN_A;
        end
        ST_GEN_A: begin
          a_byte  <= perm_rdata;
          index_j <= alu_sum;
          state   <= ST_GEN_B;
        end
        ST_GEN_B: begin
          b_byte <= perm_rdata;
          tap    <= alu_sum;
          state  <= ST_GEN_C;
        end
        ST_GEN_C: begin
          if (word_mode) begin
            word     <= {word[23:0], out_byte};
            byte_cnt <= byte_cnt + 2'd1;
            state    <= (byte_cnt == 2'd3) ? ST_OUT : ST_GEN_I;
          end else if (disc_left == 16'd1) begin
            words_left <= reseed_interval;
            state      <= ST_IDLE;
          end else begin
            disc_left <= disc_left - 16'd1;
            state     <= ST_GEN_I;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, (words_left == '0), word};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A mix or word request keeps the block busy in the following cycle.
  `ARC4_ASSERT_NEXT(a_busy_after_long, accept && (func == FUNC_MIX || func == FUNC_GEN), !s_tready)
  // A word request counts down once and saturates at zero.
  `ARC4_ASSERT_NEXT(a_count_down, accept && (func == FUNC_GEN), words_left == (($past(words_left) == '0) ? '0 : $past(words_left) - 31'd1))
  // A new result appears only when the output state loads it.
  `ARC4_ASSERT_NOW(a_out_source, $rose(m_tvalid), $past(state == ST_OUT))
  // The key position never leaves the key length.
  `ARC4_ASSERT_NOW(a_kpos_range, state == ST_MIX_RD, kpos <= KPOS_W'(KEY_BYTES - 1))

endmodule
